/* hw/rtl/bta_pkg.sv */
// Shared constants and types for the block table heap allocator.
// No dependencies; imported by every module of the block.
package bta_pkg;

  localparam int DEF_NUM_BLOCKS  = 256;
  localparam int DEF_BLOCK_BYTES = 4096;

  localparam int ADDR_W   = 32;
  localparam int BYTES_W  = 21;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;
  localparam int DIV_W    = 32;
  localparam int PADDR_W  = 3;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

  // table entry mark bits
  localparam int MARK_W     = 3;
  localparam int MARK_TAKEN = 0;
  localparam int MARK_FIRST = 1;
  localparam int MARK_NEXT  = 2;

  // register word index
  localparam logic REG_HEAP_BASE = 1'b0;

  typedef struct packed {
    logic                clr_wr;     // clearing pass: zero entry at ptr
    logic                cap;        // capture request fields
    logic                div_start;
    logic                scan_init;  // ptr to 0, drop run
    logic                step;       // ev <= ptr, ptr advances
    logic                scan_eval;  // run tracking on returned entry
    logic                need_load;
    logic                mark_init;  // ptr to start of found run
    logic                mark_wr;
    logic                walk_init;  // ptr to freed index
    logic                walk_clr;   // clear entry ev, count it
    logic                res_load;
    logic [STATUS_W-1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic zero_req;
    logic free_bad;
    logic div_done;
    logic over_need;
    logic idx_bad;
    logic run_hit;
    logic ev_last;
    logic ptr_last;
    logic mark_last;
    logic first_bad;
    logic walk_more;
    logic out_full;
  } sts_t;

endpackage

/* hw/rtl/bta_div.sv */
// Divider by a fixed divisor: reciprocal multiply, quotient valid when done pulses.
// Depends on bta_pkg.
module bta_div #(
  parameter int DIVISOR = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bta_pkg::DIV_W-1:0] dividend,
  output logic                     done,
  output logic [bta_pkg::DIV_W-1:0] quotient
);
  import bta_pkg::*;

  localparam int SH   = $clog2(DIVISOR);
  localparam int K    = DIV_W + SH;
  localparam int HALF = 17;
  localparam int PW   = DIV_W + HALF;
  localparam int SW   = DIV_W + 2 * HALF;

  // ceil(2^K / DIVISOR); error term stays below one for any 32-bit dividend
  localparam logic [63:0]     MAGIC = ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [HALF-1:0] M_LO  = MAGIC[HALF-1:0];
  localparam logic [HALF-1:0] M_HI  = MAGIC[2*HALF-1:HALF];

  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;

  logic             busy;
  logic [1:0]       stage;
  logic [DIV_W-1:0] x;
  logic [PW-1:0]    p_lo;
  logic [PW-1:0]    p_hi;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    q_full;
  logic [DIV_W-1:0] q;

  // two 32x17 partial products, summed and shifted in the last step
  assign sum      = {p_hi, {HALF{1'b0}}} + SW'(p_lo);
  assign q_full   = sum >> K;
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      stage <= PH_LO;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        stage <= PH_LO;
      end else if (busy) begin
        stage <= stage + 2'd1;
        if (stage == PH_SUM) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= dividend;
    end else if (busy) begin
      case (stage)
        PH_LO: begin
          p_lo <= PW'(x) * PW'(M_LO);
        end
        PH_HI: begin
          p_hi <= PW'(x) * PW'(M_HI);
        end
        PH_SUM: begin
          q <= q_full[DIV_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/bta_datapath.sv */
// Datapath: block table memory, scan/walk pointers, run tracking, result register.
// Depends on bta_pkg and bta_div.
module bta_datapath #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bta_pkg::cmd_t                 cmd,
  output bta_pkg::sts_t                 sts,
  input  logic [bta_pkg::ADDR_W-1:0]    heap_base,
  input  logic                          opcode,
  input  logic [bta_pkg::BYTES_W-1:0]   request_bytes,
  input  logic [bta_pkg::ADDR_W-1:0]    free_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bta_pkg::ADDR_W-1:0]    result_address,
  output logic [bta_pkg::STATUS_W-1:0]  status,
  output logic [bta_pkg::COUNT_W-1:0]   block_count
);
  import bta_pkg::*;

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  logic [MARK_W-1:0] mem [NUM_BLOCKS];
  logic [MARK_W-1:0] rd_data;

  logic              op_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [ADDR_W-1:0] addr_r;

  logic [IW-1:0]     ptr;
  logic [IW-1:0]     ptr_inc;
  logic [IW-1:0]     ev;
  logic [IW-1:0]     start_idx;
  logic [IW-1:0]     end_idx;
  logic [IW-1:0]     start_new;
  logic [CW-1:0]     need;
  logic [CW-1:0]     len;
  logic [CW-1:0]     new_len;
  logic [CW-1:0]     cnt;
  logic              in_run;
  logic              walk_first;
  logic [ADDR_W-1:0] alloc_addr;

  logic [DIV_W-1:0]  dividend;
  logic [DIV_W-1:0]  quot;
  logic              div_done;

  logic              taken;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [MARK_W-1:0] mem_wdata;
  logic [MARK_W-1:0] mark;

  assign dividend = (op_r == OP_ALLOC)
                  ? DIV_W'(bytes_r) + DIV_W'(BLOCK_BYTES - 1)
                  : addr_r - heap_base;

  bta_div #(.DIVISOR(BLOCK_BYTES)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .done     (div_done),
    .quotient (quot)
  );

  assign ptr_inc   = (ptr == IW'(NUM_BLOCKS - 1)) ? ptr : ptr + IW'(1);
  assign taken     = rd_data[MARK_TAKEN];
  assign new_len   = in_run ? len + CW'(1) : CW'(1);
  assign start_new = in_run ? start_idx : ev;

  always_comb begin
    mark             = '0;
    mark[MARK_TAKEN] = 1'b1;
    mark[MARK_FIRST] = (ptr == start_idx);
    mark[MARK_NEXT]  = (ptr != end_idx);
  end

  assign mem_we    = cmd.clr_wr | cmd.mark_wr | cmd.walk_clr;
  assign mem_waddr = cmd.walk_clr ? ev : ptr;
  assign mem_wdata = cmd.mark_wr ? mark : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r    <= opcode;
      bytes_r <= request_bytes;
      addr_r  <= free_address;
    end
    if (cmd.need_load) begin
      need <= CW'(quot);
    end
    if (cmd.scan_eval) begin
      if (taken) begin
        in_run <= 1'b0;
      end else begin
        in_run    <= 1'b1;
        len       <= new_len;
        start_idx <= start_new;
        end_idx   <= ev;
      end
    end else if (cmd.scan_init) begin
      in_run <= 1'b0;
    end
    if (cmd.step) begin
      ev <= ptr;
    end
    if (cmd.walk_init) begin
      cnt        <= '0;
      walk_first <= 1'b1;
    end else if (cmd.walk_clr) begin
      cnt        <= cnt + CW'(1);
      walk_first <= 1'b0;
    end
    if (cmd.mark_wr) begin
      alloc_addr <= heap_base + ADDR_W'(ADDR_W'(start_idx) * ADDR_W'(BLOCK_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.scan_init) begin
      ptr <= '0;
    end else if (cmd.walk_init) begin
      ptr <= IW'(quot);
    end else if (cmd.mark_init) begin
      ptr <= start_new;
    end else if (cmd.clr_wr || cmd.mark_wr || cmd.step) begin
      ptr <= ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status         <= cmd.res_code;
      result_address <= '0;
      block_count    <= '0;
      if (cmd.res_code == ST_DONE) begin
        if (op_r == OP_ALLOC) begin
          result_address <= alloc_addr;
          block_count    <= COUNT_W'(need);
        end else begin
          block_count    <= COUNT_W'(cnt);
        end
      end
    end
  end

  always_comb begin
    sts           = '0;
    sts.op        = op_r;
    sts.zero_req  = (bytes_r == '0);
    sts.free_bad  = (addr_r == '0) || (addr_r < heap_base);
    sts.div_done  = div_done;
    sts.over_need = quot > DIV_W'(NUM_BLOCKS);
    sts.idx_bad   = quot >= DIV_W'(NUM_BLOCKS);
    sts.run_hit   = !taken && (new_len == need);
    sts.ev_last   = (ev == IW'(NUM_BLOCKS - 1));
    sts.ptr_last  = (ptr == IW'(NUM_BLOCKS - 1));
    sts.mark_last = (ptr == end_idx);
    sts.first_bad = walk_first && !rd_data[MARK_FIRST];
    sts.walk_more = rd_data[MARK_NEXT] && (ev != IW'(NUM_BLOCKS - 1));
    sts.out_full  = out_valid && !out_ready;
  end

endmodule

/* hw/rtl/bta_ctrl.sv */
// Controller state machine: sequences clearing, division, scan, marking and free walk.
// Depends on bta_pkg.
module bta_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bta_pkg::sts_t sts,
  output bta_pkg::cmd_t cmd
);
  import bta_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_SCAN0 = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_MARK  = 4'd7;
  localparam logic [3:0] S_WALK0 = 4'd8;
  localparam logic [3:0] S_WALK  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    code_next    = code;
    cmd          = '0;
    cmd.res_code = code;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.ptr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.op == OP_ALLOC && sts.zero_req) begin
          code_next  = ST_ZERO;
          state_next = S_FIN;
        end else if (sts.op == OP_FREE && sts.free_bad) begin
          code_next  = ST_IGNORED;
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.op == OP_ALLOC) begin
          if (sts.over_need) begin
            code_next  = ST_NOFIT;
            state_next = S_FIN;
          end else begin
            cmd.need_load = 1'b1;
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN0;
          end
        end else begin
          if (sts.idx_bad) begin
            code_next  = ST_IGNORED;
            state_next = S_FIN;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = S_WALK0;
          end
        end
      end
      S_SCAN0: begin
        cmd.step   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_eval = 1'b1;
        if (sts.run_hit) begin
          cmd.mark_init = 1'b1;
          state_next    = S_MARK;
        end else if (sts.ev_last) begin
          code_next  = ST_NOFIT;
          state_next = S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_MARK: begin
        cmd.mark_wr = 1'b1;
        if (sts.mark_last) begin
          code_next  = ST_DONE;
          state_next = S_FIN;
        end
      end
      S_WALK0: begin
        cmd.step   = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.first_bad) begin
          code_next  = ST_IGNORED;
          state_next = S_FIN;
        end else begin
          cmd.walk_clr = 1'b1;
          if (sts.walk_more) begin
            cmd.step = 1'b1;
          end else begin
            code_next  = ST_DONE;
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!sts.out_full) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

/* hw/rtl/block_table_heap_allocator.sv */
// First-fit block table heap allocator. After reset the block runs a clearing pass over
// the table memory and takes no request until it ends (register writes are taken
// throughout). One request is in work at a time. An allocate uses the reciprocal multiply
// (two partial products, then a sum) to round the size to blocks, then a scan of one
// table entry per cycle up to the index where the first fitting run ends (at most
// NUM_BLOCKS - 1), then marks the run. A free uses the same multiply to find the block
// index, then walks and clears the has-next chain one entry per cycle. A result can wait
// in the output register while the next request is accepted. block_count carries the
// low 9 bits.
module block_table_heap_allocator #(
  parameter int NUM_BLOCKS  = bta_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = bta_pkg::DEF_BLOCK_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bta_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [bta_pkg::BYTES_W-1:0]   request_bytes,
  input  logic [bta_pkg::ADDR_W-1:0]    free_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bta_pkg::ADDR_W-1:0]    result_address,
  output logic [bta_pkg::STATUS_W-1:0]  status,
  output logic [bta_pkg::COUNT_W-1:0]   block_count
);
  import bta_pkg::*;

  logic [ADDR_W-1:0] heap_base;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_BASE) ? heap_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_HEAP_BASE) begin
      heap_base <= pwdata;
    end
  end

  bta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bta_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .heap_base      (heap_base),
    .opcode         (opcode),
    .request_bytes  (request_bytes),
    .free_address   (free_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_address (result_address),
    .status         (status),
    .block_count    (block_count)
  );

endmodule
